@@ design/rfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants of the request frame packer
// Queue entry layout between front and back, envelope byte constants.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam logic [7:0] SYNC_A     = 8'h98;
	localparam logic [7:0] SYNC_B     = 8'hF3;
	localparam logic [7:0] TYPE_REQ   = 8'h5A;
	localparam logic [7:0] TERM_BYTE  = 8'hA5;
	localparam logic [7:0] LEN_OFFSET = 8'd11;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
	localparam int SERIAL_W = 48;

	typedef struct packed {
		logic       err;
		logic       hdr;
		logic       has_byte;
		logic       trl;
		logic [7:0] data;
		logic [7:0] olen;
	} entry_t;

endpackage

@@ design/rfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_front: request classifier
// Accepts input items, tracks rejected requests, builds queue entries.
// ----------------------------------------------------------------------------
module rfp_front #(
	parameter int MAX_PAYLOAD = 244
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      payload_byte,
	input  logic [7:0]      req_len,
	input  logic            is_first,
	input  logic            is_last,
	input  logic            no_payload,
	input  logic            q_full,
	output logic            q_push,
	output rfp_pkg::entry_t q_entry
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	logic rejected_q;
	logic accept;
	logic len_bad;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign len_bad  = req_len > MaxLen;

	always_comb begin
		q_entry          = '0;
		q_entry.data     = payload_byte;
		q_entry.olen     = req_len + rfp_pkg::LEN_OFFSET;
		q_entry.has_byte = !no_payload;
		q_entry.trl      = is_last;
		q_push           = 1'b0;
		if (is_first) begin
			q_entry.hdr = 1'b1;
			if (len_bad) begin
				q_entry          = '0;
				q_entry.err      = 1'b1;
			end
			q_push = accept;
		end else if (!rejected_q) begin
			q_push = accept && (!no_payload || is_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rejected_q <= 1'b0;
		end else if (accept) begin
			if (is_first) begin
				rejected_q <= len_bad && !is_last;
			end else if (is_last) begin
				rejected_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/rfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_queue: entry queue
// Small register queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module rfp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rfp_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output rfp_pkg::entry_t head_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	rfp_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = count_q == FullCnt;
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

@@ design/rfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_back: frame byte sequencer
// Expands queue entries into frame bytes, one per cycle while the output does not stall, with CRC-16/X.25.
// ----------------------------------------------------------------------------
module rfp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rfp_pkg::SERIAL_W-1:0]  serial,
	input  logic                          head_valid,
	input  rfp_pkg::entry_t               head_entry,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          frame_end,
	output logic                          too_long
);

	typedef enum logic [4:0] {
		ST_SYNC_A,
		ST_SYNC_B,
		ST_OLEN,
		ST_ZERO,
		ST_ONE,
		ST_HLEN,
		ST_TYPE,
		ST_SER0,
		ST_SER1,
		ST_SER2,
		ST_SER3,
		ST_SER4,
		ST_SER5,
		ST_DATA,
		ST_TERM,
		ST_CRC_LO,
		ST_CRC_HI,
		ST_ERR
	} step_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ rfp_pkg::CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

	logic        busy_q;
	step_t       step_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic        too_long_q;

	step_t       first_step;
	step_t       cur_step;
	step_t       next_step;
	logic        done;
	logic        can_emit;
	logic [7:0]  byte_val;
	logic [15:0] crc_out;
	logic [15:0] crc_base;

	assign first_step = head_entry.err      ? ST_ERR :
	                    head_entry.hdr      ? ST_SYNC_A :
	                    head_entry.has_byte ? ST_DATA : ST_TERM;
	assign cur_step = busy_q ? step_q : first_step;
	assign can_emit = head_valid && (!out_valid_q || !out_stall);
	assign pop      = can_emit && done;
	assign crc_out  = crc_q ^ rfp_pkg::CRC_XOROUT;
	assign crc_base = (cur_step == ST_OLEN) ? rfp_pkg::CRC_INIT : crc_q;

	always_comb begin
		next_step = ST_SYNC_A;
		done      = 1'b0;
		case (cur_step)
			ST_SER5: begin
				if (head_entry.has_byte) next_step = ST_DATA;
				else if (head_entry.trl) next_step = ST_TERM;
				else done = 1'b1;
			end
			ST_DATA: begin
				if (head_entry.trl) next_step = ST_TERM;
				else done = 1'b1;
			end
			ST_CRC_HI: done = 1'b1;
			ST_ERR:    done = 1'b1;
			default:   next_step = step_t'(cur_step + 5'd1);
		endcase
	end

	always_comb begin
		case (cur_step)
			ST_SYNC_A: byte_val = rfp_pkg::SYNC_A;
			ST_SYNC_B: byte_val = rfp_pkg::SYNC_B;
			ST_OLEN:   byte_val = head_entry.olen;
			ST_ZERO:   byte_val = 8'h00;
			ST_ONE:    byte_val = 8'h01;
			ST_HLEN:   byte_val = head_entry.olen ^ 8'h01;
			ST_TYPE:   byte_val = rfp_pkg::TYPE_REQ;
			ST_SER0:   byte_val = serial[7:0];
			ST_SER1:   byte_val = serial[15:8];
			ST_SER2:   byte_val = serial[23:16];
			ST_SER3:   byte_val = serial[31:24];
			ST_SER4:   byte_val = serial[39:32];
			ST_SER5:   byte_val = serial[47:40];
			ST_DATA:   byte_val = head_entry.data;
			ST_TERM:   byte_val = rfp_pkg::TERM_BYTE;
			ST_CRC_LO: byte_val = crc_out[7:0];
			ST_CRC_HI: byte_val = crc_out[15:8];
			default:   byte_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_SYNC_A;
			crc_q       <= rfp_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			frame_end_q <= 1'b0;
			too_long_q  <= 1'b0;
		end else if (can_emit) begin
			busy_q      <= !done;
			step_q      <= next_step;
			out_valid_q <= 1'b1;
			out_byte_q  <= byte_val;
			frame_end_q <= (cur_step == ST_CRC_HI) || (cur_step == ST_ERR);
			too_long_q  <= cur_step == ST_ERR;
			if (cur_step >= ST_OLEN && cur_step <= ST_TERM) begin
				crc_q <= crc_byte(crc_base, byte_val);
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign too_long  = too_long_q;

	a_busy_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> head_valid)
		else $error("sequencer mid-entry without queue head");
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && too_long_q |-> frame_end_q)
		else $error("error result without frame end");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		can_emit && cur_step == ST_ERR |-> pop && !busy_q)
		else $error("error entry not finished in one step");

endmodule

@@ design/request_frame_packer_crc16.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_frame_packer_crc16: length-prefixed request framer with CRC-16/X.25
// Input items carry payload bytes; output is the on-air frame, byte by byte.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries one payload item per transaction;
//   is_first on the first item emits the 13-byte header, is_last emits A5 and
//   the two crc bytes, no_payload suppresses the item's own byte.
//   output channel out_valid/out_stall carries one frame byte per transaction.
//   cfg channel cfg_valid/cfg_ready writes the six serial bytes; write it only
//   while no request is in flight.
// path: an accepted item enters the queue; its first byte is registered at the
//   output once it is at the queue head. throughput: one byte per cycle from the
//   sequencer while the queue holds an entry and the output does not stall.
// the input side runs ahead through a QUEUE_DEPTH entry queue and stalls only
//   when it is full; a too-long request gives one error byte and is dropped.
// reset: queue empty, crc FFFF, no rejected request, serial bytes zero.
// a stall on the output holds the current byte; the queue keeps filling.
// ----------------------------------------------------------------------------
module request_frame_packer_crc16 #(
	parameter int MAX_PAYLOAD = 244,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rfp_pkg::SERIAL_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   payload_byte,
	input  logic [7:0]                   req_len,
	input  logic                         is_first,
	input  logic                         is_last,
	input  logic                         no_payload,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         frame_end,
	output logic                         too_long
);

	logic [rfp_pkg::SERIAL_W-1:0] serial_q;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_head_valid;
	rfp_pkg::entry_t q_entry;
	rfp_pkg::entry_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= '0;
		end else if (cfg_valid) begin
			serial_q <= cfg_data;
		end
	end

	rfp_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.req_len      (req_len),
		.is_first     (is_first),
		.is_last      (is_last),
		.no_payload   (no_payload),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_entry)
	);

	rfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_entry (q_head)
	);

	rfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.serial     (serial_q),
		.head_valid (q_head_valid),
		.head_entry (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.too_long   (too_long)
	);

endmodule
